@@ rtl/fbrect_pkg.sv @@
package fbrect_pkg;

    localparam int unsigned MAX_DIM = 4096;

    localparam logic [1:0] CMD_BLIT  = 2'd0;
    localparam logic [1:0] CMD_FILL  = 2'd1;
    localparam logic [1:0] CMD_PIXEL = 2'd2;

    localparam logic [1:0] ST_WRITE  = 2'd0;
    localparam logic [1:0] ST_START  = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;
    localparam logic [1:0] ST_IDLE   = 2'd3;

    localparam logic [2:0] REG_SCREEN_WIDTH   = 3'd0;
    localparam logic [2:0] REG_SCREEN_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_PAN_X          = 3'd2;
    localparam logic [2:0] REG_PAN_Y          = 3'd3;
    localparam logic [2:0] REG_LINE_STRIDE    = 3'd4;
    localparam logic [2:0] REG_BYTES_PER_PIX  = 3'd5;
    localparam logic [2:0] REG_CHANNEL_LAYOUT = 3'd6;
    localparam logic [2:0] REG_FRAME_BASE     = 3'd7;

    typedef struct packed {
        logic [12:0] screen_width;
        logic [12:0] screen_height;
        logic [11:0] pan_x;
        logic [12:0] pan_y;
        logic [15:0] line_stride;
        logic [2:0]  bytes_per_pixel;
        logic [26:0] channel_layout;
        logic [31:0] frame_base;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        screen_width:    13'd1920,
        screen_height:   13'd1080,
        pan_x:           12'd0,
        pan_y:           13'd0,
        line_stride:     16'd7680,
        bytes_per_pixel: 3'd4,
        channel_layout:  27'd8438800,
        frame_base:      32'd0
    };

    // one request between the control stage and the write stage
    typedef struct packed {
        logic [1:0]  status;
        logic [13:0] line;
        logic [13:0] col;
        logic [23:0] rgb;
        logic        last;
    } t_job;

endpackage

@@ rtl/framebuffer_rect_blit_fill.sv @@
// Rectangle writer for a linear packed-pixel framebuffer.
// Input channel (i_valid / o_stall): one request per accepted cycle. Start
// commands (blit or fill) open a rectangle checked against the screen size;
// pixel commands each produce one result, a write request while a rectangle
// is open; the unused command code is consumed and produces nothing.
// Output channel (o_valid / i_stall): status, byte address, packed data,
// byte count and a last flag on the final pixel of the rectangle.
// A control stage (rectangle walk, coordinate sums) and a write stage
// (address multiply-add, channel packing) each end in a register.
// Throughput is one request per clock while the output is not stalled;
// the line-stride multiply in the write stage sets the clock period.
// A stall on the output holds the result register; the control stage keeps
// accepting until it too is full, then o_stall rises in the same cycle.
// Reset (synchronous, active low) empties both stages, closes any open
// rectangle and loads the register defaults (1920x1080, stride 7680,
// 4 bytes per pixel, base 0, layout red 0 bits at 16, green 3 bits at 2,
// blue 1 bit at 0). Configuration is written through
// i_cfg_we / i_cfg_index / i_cfg_data while no requests are in flight.
module framebuffer_rect_blit_fill (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_command,
    input  logic [11:0] i_rect_x,
    input  logic [11:0] i_rect_y,
    input  logic [12:0] i_rect_w,
    input  logic [12:0] i_rect_h,
    input  logic        i_flip,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [31:0] o_write_address,
    output logic [31:0] o_write_data,
    output logic [2:0]  o_byte_count,
    output logic        o_last
);
    import fbrect_pkg::*;

    t_cfg r_cfg;
    t_job job;
    logic job_valid;
    logic out_ready;
    logic advance;
    logic accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SCREEN_WIDTH:   r_cfg.screen_width    <= i_cfg_data[12:0];
                REG_SCREEN_HEIGHT:  r_cfg.screen_height   <= i_cfg_data[12:0];
                REG_PAN_X:          r_cfg.pan_x           <= i_cfg_data[11:0];
                REG_PAN_Y:          r_cfg.pan_y           <= i_cfg_data[12:0];
                REG_LINE_STRIDE:    r_cfg.line_stride     <= i_cfg_data[15:0];
                REG_BYTES_PER_PIX:  r_cfg.bytes_per_pixel <= i_cfg_data[2:0];
                REG_CHANNEL_LAYOUT: r_cfg.channel_layout  <= i_cfg_data[26:0];
                REG_FRAME_BASE:     r_cfg.frame_base      <= i_cfg_data;
                default:            r_cfg                 <= r_cfg;
            endcase
        end
    end

    assign out_ready = !o_valid || !i_stall;
    assign advance   = job_valid && out_ready;
    assign o_stall   = job_valid && !out_ready;
    assign accept    = i_valid && !o_stall;

    fbrect_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_accept    (accept),
        .i_advance   (advance),
        .i_command   (i_command),
        .i_rect_x    (i_rect_x),
        .i_rect_y    (i_rect_y),
        .i_rect_w    (i_rect_w),
        .i_rect_h    (i_rect_h),
        .i_flip      (i_flip),
        .i_red       (i_red),
        .i_green     (i_green),
        .i_blue      (i_blue),
        .o_job_valid (job_valid),
        .o_job       (job)
    );

    fbrect_write u_write (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_load          (advance),
        .i_unload        (!i_stall),
        .i_job           (job),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_write_address (o_write_address),
        .o_write_data    (o_write_data),
        .o_byte_count    (o_byte_count),
        .o_last          (o_last)
    );

endmodule

@@ rtl/fbrect_ctrl.sv @@
module fbrect_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fbrect_pkg::t_cfg   i_cfg,
    input  logic               i_accept,
    input  logic               i_advance,
    input  logic [1:0]         i_command,
    input  logic [11:0]        i_rect_x,
    input  logic [11:0]        i_rect_y,
    input  logic [12:0]        i_rect_w,
    input  logic [12:0]        i_rect_h,
    input  logic               i_flip,
    input  logic [7:0]         i_red,
    input  logic [7:0]         i_green,
    input  logic [7:0]         i_blue,
    output logic               o_job_valid,
    output fbrect_pkg::t_job   o_job
);
    import fbrect_pkg::*;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_BLIT = 2'd1;
    localparam logic [1:0] MODE_FILL = 2'd2;

    localparam logic [12:0] DIM_LIMIT = 13'(MAX_DIM > 8191 ? 8191 : MAX_DIM);
    localparam logic        DIM_ANY   = (MAX_DIM > 8191);

    logic [1:0]  r_mode,  n_mode;
    logic [11:0] r_x,     n_x;
    logic [11:0] r_y,     n_y;
    logic [12:0] r_w,     n_w;
    logic [12:0] r_h,     n_h;
    logic        r_flip,  n_flip;
    logic [11:0] r_col,   n_col;
    logic [11:0] r_row,   n_row;
    logic [23:0] r_fill,  n_fill;
    logic        r_valid, n_valid;
    t_job        r_job,   n_job;

    logic        ok;
    logic [12:0] col_inc;
    logic [12:0] row_inc;
    logic [11:0] dst_row;
    logic [13:0] x_end;
    logic [13:0] y_end;
    logic        w_ok;
    logic        h_ok;

    always_comb begin
        x_end   = {2'b0, i_rect_x} + {1'b0, i_rect_w};
        y_end   = {2'b0, i_rect_y} + {1'b0, i_rect_h};
        w_ok    = (i_rect_w != '0) && (DIM_ANY || i_rect_w <= DIM_LIMIT);
        h_ok    = (i_rect_h != '0) && (DIM_ANY || i_rect_h <= DIM_LIMIT);
        ok      = w_ok && h_ok && (x_end <= {1'b0, i_cfg.screen_width})
                  && (y_end <= {1'b0, i_cfg.screen_height});
        col_inc = {1'b0, r_col} + 13'd1;
        row_inc = {1'b0, r_row} + 13'd1;
        dst_row = r_flip ? 12'(r_h - 13'd1 - {1'b0, r_row}) : r_row;

        n_mode  = r_mode;
        n_x     = r_x;
        n_y     = r_y;
        n_w     = r_w;
        n_h     = r_h;
        n_flip  = r_flip;
        n_col   = r_col;
        n_row   = r_row;
        n_fill  = r_fill;
        n_valid = 1'b1;
        n_job   = '0;

        unique case (i_command)
            CMD_BLIT, CMD_FILL: begin
                if (!ok) begin
                    n_mode       = MODE_IDLE;
                    n_job.status = ST_REJECT;
                end else begin
                    n_mode       = (i_command == CMD_BLIT) ? MODE_BLIT : MODE_FILL;
                    n_x          = i_rect_x;
                    n_y          = i_rect_y;
                    n_w          = i_rect_w;
                    n_h          = i_rect_h;
                    n_flip       = (i_command == CMD_BLIT) ? i_flip : 1'b0;
                    n_col        = '0;
                    n_row        = '0;
                    if (i_command == CMD_FILL) begin
                        n_fill = {i_red, i_green, i_blue};
                    end
                    n_job.status = ST_START;
                end
            end
            CMD_PIXEL: begin
                if (r_mode != MODE_BLIT && r_mode != MODE_FILL) begin
                    n_job.status = ST_IDLE;
                end else begin
                    n_job.status = ST_WRITE;
                    n_job.line   = {2'b0, r_y} + {1'b0, i_cfg.pan_y} + {2'b0, dst_row};
                    n_job.col    = {2'b0, r_x} + {2'b0, i_cfg.pan_x} + {2'b0, r_col};
                    n_job.rgb    = (r_mode == MODE_FILL) ? r_fill
                                                         : {i_red, i_green, i_blue};
                    if (col_inc >= r_w) begin
                        n_col = '0;
                        if (row_inc >= r_h) begin
                            n_row      = '0;
                            n_job.last = 1'b1;
                            n_mode     = MODE_IDLE;
                        end else begin
                            n_row = row_inc[11:0];
                        end
                    end else begin
                        n_col = col_inc[11:0];
                    end
                end
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_x     <= '0;
            r_y     <= '0;
            r_w     <= '0;
            r_h     <= '0;
            r_flip  <= 1'b0;
            r_col   <= '0;
            r_row   <= '0;
            r_fill  <= '0;
            r_valid <= 1'b0;
        end else if (i_accept) begin
            r_mode  <= n_mode;
            r_x     <= n_x;
            r_y     <= n_y;
            r_w     <= n_w;
            r_h     <= n_h;
            r_flip  <= n_flip;
            r_col   <= n_col;
            r_row   <= n_row;
            r_fill  <= n_fill;
            r_valid <= n_valid;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_job <= n_job;
        end
    end

    assign o_job_valid = r_valid;
    assign o_job       = r_job;

endmodule

@@ rtl/fbrect_write.sv @@
module fbrect_write (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fbrect_pkg::t_cfg   i_cfg,
    input  logic               i_load,
    input  logic               i_unload,
    input  fbrect_pkg::t_job   i_job,
    output logic               o_valid,
    output logic [1:0]         o_status,
    output logic [31:0]        o_write_address,
    output logic [31:0]        o_write_data,
    output logic [2:0]         o_byte_count,
    output logic               o_last
);
    import fbrect_pkg::*;

    function automatic logic [31:0] f_chan(input logic [7:0] v, input logic [3:0] len,
                                           input logic [4:0] off);
        logic [7:0]  bits;
        logic [39:0] wide;
        begin
            if (len == 4'd0) begin
                bits = '0;
            end else if (len >= 4'd8) begin
                bits = v;
            end else begin
                bits = v >> (4'd8 - len);
            end
            wide = {32'b0, bits} << off;
            return wide[31:0];
        end
    endfunction

    logic        r_valid;
    logic [1:0]  r_status,  n_status;
    logic [31:0] r_address, n_address;
    logic [31:0] r_data,    n_data;
    logic [2:0]  r_count,   n_count;
    logic        r_last,    n_last;

    logic [29:0] line_bytes;
    logic [16:0] col_bytes;
    logic [31:0] packed_px;
    logic [31:0] mask;
    logic [2:0]  cnt;
    logic [26:0] cl;

    always_comb begin
        cl         = i_cfg.channel_layout;
        line_bytes = i_job.line * i_cfg.line_stride;
        col_bytes  = i_job.col * i_cfg.bytes_per_pixel;
        packed_px  = f_chan(i_job.rgb[23:16], cl[8:5],   cl[4:0])
                   | f_chan(i_job.rgb[15:8],  cl[17:14], cl[13:9])
                   | f_chan(i_job.rgb[7:0],   cl[26:23], cl[22:18]);
        cnt        = (i_cfg.bytes_per_pixel > 3'd4) ? 3'd4 : i_cfg.bytes_per_pixel;
        unique case (cnt)
            3'd0:    mask = 32'h0000_0000;
            3'd1:    mask = 32'h0000_00FF;
            3'd2:    mask = 32'h0000_FFFF;
            3'd3:    mask = 32'h00FF_FFFF;
            default: mask = 32'hFFFF_FFFF;
        endcase

        n_status  = i_job.status;
        n_last    = i_job.last;
        if (i_job.status == ST_WRITE) begin
            n_address = i_cfg.frame_base + {2'b0, line_bytes} + {15'b0, col_bytes};
            n_data    = packed_px & mask;
            n_count   = cnt;
        end else begin
            n_address = '0;
            n_data    = '0;
            n_count   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_unload) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_status  <= n_status;
            r_address <= n_address;
            r_data    <= n_data;
            r_count   <= n_count;
            r_last    <= n_last;
        end
    end

    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_write_address = r_address;
    assign o_write_data    = r_data;
    assign o_byte_count    = r_count;
    assign o_last          = r_last;

endmodule

@@ sim/tb_framebuffer_rect_blit_fill.sv @@
module tb_framebuffer_rect_blit_fill;
    timeunit 1ns;
    timeprecision 1ps;

    import fbrect_pkg::*;

    localparam logic [1:0] CMD_UNUSED     = 2'd3;
    localparam int         HOLDOFF_CYCLES = 400;
    localparam int         WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic [1:0]  command;
        logic [11:0] rect_x;
        logic [11:0] rect_y;
        logic [12:0] rect_w;
        logic [12:0] rect_h;
        logic        flip;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        drain_first;
    } t_fb_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] address;
        logic [31:0] data;
        logic [2:0]  count;
        logic        last;
    } t_fb_write;

    typedef enum logic [1:0] {BOX_IDLE, BOX_BLIT, BOX_FILL} t_box_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_command;
    logic [11:0] i_rect_x;
    logic [11:0] i_rect_y;
    logic [12:0] i_rect_w;
    logic [12:0] i_rect_h;
    logic        i_flip;
    logic [7:0]  i_red;
    logic [7:0]  i_green;
    logic [7:0]  i_blue;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_status;
    logic [31:0] o_write_address;
    logic [31:0] o_write_data;
    logic [2:0]  o_byte_count;
    logic        o_last;

    t_fb_req     cmd_queue[$];
    t_fb_write   fb_writes_due[$];
    t_fb_req     cur_req = '0;
    bit          req_live = 1'b0;
    int unsigned req_count = 0;
    int          snd_idle_pct = 0;
    int          rcv_stall_pct = 0;
    bit          holdoff_go = 1'b0;
    int          hold_left = 0;
    int          fail_count = 0;
    int          quiet_cycles = 0;

    // block state as seen by the predictor
    t_cfg        fb_cfg = CFG_RESET;
    t_box_mode   box_mode = BOX_IDLE;
    int unsigned box_x = 0, box_y = 0, box_w = 0, box_h = 0;
    logic        box_flip = 1'b0;
    int unsigned col_pos = 0, row_pos = 0;
    logic [23:0] fill_rgb = '0;

    assign i_command = cur_req.command;
    assign i_rect_x  = cur_req.rect_x;
    assign i_rect_y  = cur_req.rect_y;
    assign i_rect_w  = cur_req.rect_w;
    assign i_rect_h  = cur_req.rect_h;
    assign i_flip    = cur_req.flip;
    assign i_red     = cur_req.red;
    assign i_green   = cur_req.green;
    assign i_blue    = cur_req.blue;

    framebuffer_rect_blit_fill u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_command       (i_command),
        .i_rect_x        (i_rect_x),
        .i_rect_y        (i_rect_y),
        .i_rect_w        (i_rect_w),
        .i_rect_h        (i_rect_h),
        .i_flip          (i_flip),
        .i_red           (i_red),
        .i_green         (i_green),
        .i_blue          (i_blue),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_write_address (o_write_address),
        .o_write_data    (o_write_data),
        .o_byte_count    (o_byte_count),
        .o_last          (o_last)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [63:0] chan_top(input logic [7:0] v, input logic [3:0] len);
        if (len == 0) return 64'd0;
        if (len >= 8) return v;
        return v >> (8 - len);
    endfunction

    function automatic logic [31:0] pack_channels(input logic [23:0] rgb);
        logic [26:0] lay;
        logic [63:0] bits;
        lay = fb_cfg.channel_layout;
        bits = (chan_top(rgb[23:16], lay[8:5]) << lay[4:0])
             | (chan_top(rgb[15:8], lay[17:14]) << lay[13:9])
             | (chan_top(rgb[7:0], lay[26:23]) << lay[22:18]);
        return bits[31:0];
    endfunction

    task automatic compute_fb_write(input t_fb_req rq);
        t_fb_write       res;
        int unsigned     x, y, w, h, dst_row, nbytes;
        longint unsigned line, col, addr;
        logic [23:0]     rgb;
        logic [31:0]     mask;
        res = '0;
        x = rq.rect_x;
        y = rq.rect_y;
        w = rq.rect_w;
        h = rq.rect_h;
        if (rq.command == CMD_BLIT || rq.command == CMD_FILL) begin
            if (w >= 1 && h >= 1 && w <= MAX_DIM && h <= MAX_DIM &&
                x + w <= fb_cfg.screen_width && y + h <= fb_cfg.screen_height) begin
                box_mode = (rq.command == CMD_BLIT) ? BOX_BLIT : BOX_FILL;
                box_x = x;
                box_y = y;
                box_w = w;
                box_h = h;
                box_flip = (rq.command == CMD_BLIT) ? rq.flip : 1'b0;
                col_pos = 0;
                row_pos = 0;
                if (rq.command == CMD_FILL) fill_rgb = {rq.red, rq.green, rq.blue};
                res.status = ST_START;
            end else begin
                box_mode = BOX_IDLE;
                res.status = ST_REJECT;
            end
            fb_writes_due.push_back(res);
        end else if (rq.command == CMD_PIXEL) begin
            if (box_mode == BOX_IDLE) begin
                res.status = ST_IDLE;
            end else begin
                dst_row = box_flip ? box_h - 1 - row_pos : row_pos;
                line = box_y + fb_cfg.pan_y + dst_row;
                col = box_x + fb_cfg.pan_x + col_pos;
                addr = fb_cfg.frame_base + line * fb_cfg.line_stride
                     + col * fb_cfg.bytes_per_pixel;
                nbytes = (fb_cfg.bytes_per_pixel > 4) ? 4 : fb_cfg.bytes_per_pixel;
                mask = (nbytes >= 4) ? 32'hFFFF_FFFF : (32'h1 << (8 * nbytes)) - 1;
                rgb = (box_mode == BOX_FILL) ? fill_rgb : {rq.red, rq.green, rq.blue};
                res.status = ST_WRITE;
                res.address = 32'(addr);
                res.data = pack_channels(rgb) & mask;
                res.count = 3'(nbytes);
                col_pos++;
                if (col_pos >= box_w) begin
                    col_pos = 0;
                    row_pos++;
                    if (row_pos >= box_h) begin
                        row_pos = 0;
                        res.last = 1'b1;
                        box_mode = BOX_IDLE;
                    end
                end
            end
            fb_writes_due.push_back(res);
        end
    endtask

    function automatic t_fb_req rand_req(input logic [1:0] cmd);
        t_fb_req rq;
        rq.command = cmd;
        rq.rect_x = $urandom_range(0, 4095);
        rq.rect_y = $urandom_range(0, 4095);
        rq.rect_w = $urandom_range(0, 8191);
        rq.rect_h = $urandom_range(0, 8191);
        rq.flip = $urandom_range(0, 1);
        rq.red = $urandom_range(0, 255);
        rq.green = $urandom_range(0, 255);
        rq.blue = $urandom_range(0, 255);
        rq.drain_first = 1'b0;
        return rq;
    endfunction

    task automatic queue_req(input t_fb_req rq);
        cmd_queue.push_back(rq);
        if (rq.command != CMD_UNUSED) req_count++;
    endtask

    task automatic add_start(input logic [1:0] cmd, input int unsigned x, y, w, h,
                             input logic fl, input logic [23:0] rgb, input bit drain);
        t_fb_req rq;
        rq = rand_req(cmd);
        rq.rect_x = x;
        rq.rect_y = y;
        rq.rect_w = w;
        rq.rect_h = h;
        rq.flip = fl;
        {rq.red, rq.green, rq.blue} = rgb;
        rq.drain_first = drain;
        queue_req(rq);
    endtask

    task automatic add_pixel(input logic [23:0] rgb);
        t_fb_req rq;
        rq = rand_req(CMD_PIXEL);
        {rq.red, rq.green, rq.blue} = rgb;
        queue_req(rq);
    endtask

    // mostly complete rectangles, some cut short, plus rejected starts,
    // stray pixels and unused codes
    task automatic gen_traffic(input int unsigned n);
        int unsigned first, sel, w, h, x, y, npix;
        first = req_count;
        while (req_count - first < n) begin
            sel = $urandom_range(0, 99);
            if (sel < 75) begin
                w = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 6);
                h = $urandom_range(1, 4);
                if (w > fb_cfg.screen_width) w = fb_cfg.screen_width;
                if (h > fb_cfg.screen_height) h = fb_cfg.screen_height;
                x = $urandom_range(0, fb_cfg.screen_width - w);
                y = $urandom_range(0, fb_cfg.screen_height - h);
                add_start($urandom_range(0, 1) ? CMD_FILL : CMD_BLIT, x, y, w, h,
                          $urandom_range(0, 1), $urandom_range(0, 24'hFFFFFF),
                          $urandom_range(0, 9) == 0);
                npix = w * h;
                if ($urandom_range(0, 6) == 0) npix = $urandom_range(0, npix - 1);
                repeat (npix) add_pixel($urandom_range(0, 24'hFFFFFF));
            end else if (sel < 85) begin
                queue_req(rand_req($urandom_range(0, 1) ? CMD_FILL : CMD_BLIT));
            end else if (sel < 93) begin
                add_pixel($urandom_range(0, 24'hFFFFFF));
            end else begin
                queue_req(rand_req(CMD_UNUSED));
            end
        end
    endtask

    function automatic logic [26:0] chan_layout(input logic [4:0] ro, input logic [3:0] rl,
                                                input logic [4:0] go, input logic [3:0] gl,
                                                input logic [4:0] bo, input logic [3:0] bl);
        return {bl, bo, gl, go, rl, ro};
    endfunction

    function automatic t_cfg rand_cfg(input logic [2:0] bpp);
        t_cfg c;
        c.screen_width = ($urandom_range(0, 3) == 0) ? 4096 : $urandom_range(16, 4096);
        c.screen_height = ($urandom_range(0, 3) == 0) ? 4096 : $urandom_range(16, 4096);
        c.pan_x = $urandom_range(0, 4095);
        c.pan_y = $urandom_range(0, 8191);
        c.line_stride = $urandom_range(1, 65535);
        c.bytes_per_pixel = bpp;
        case ($urandom_range(0, 3))
            0: c.channel_layout = $urandom_range(0, 27'h7FF_FFFF);
            1: c.channel_layout = chan_layout(11, 5, 5, 6, 0, 5);
            2: c.channel_layout = chan_layout(16, 8, 8, 8, 0, 8);
            default: c.channel_layout = chan_layout(10, 5, 5, 5, 0, 5);
        endcase
        c.frame_base = $urandom;
        return c;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
    endtask

    task automatic program_cfg(input t_cfg c);
        write_reg(REG_SCREEN_WIDTH, c.screen_width);
        write_reg(REG_SCREEN_HEIGHT, c.screen_height);
        write_reg(REG_PAN_X, c.pan_x);
        write_reg(REG_PAN_Y, c.pan_y);
        write_reg(REG_LINE_STRIDE, c.line_stride);
        write_reg(REG_BYTES_PER_PIX, c.bytes_per_pixel);
        write_reg(REG_CHANNEL_LAYOUT, c.channel_layout);
        write_reg(REG_FRAME_BASE, c.frame_base);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        fb_cfg = c;
    endtask

    // extra cycles cover an unused command still in the pipe
    task automatic wait_drained();
        while (cmd_queue.size() != 0 || req_live || fb_writes_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : req_driver
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                compute_fb_write(cur_req);
                req_live = 1'b0;
            end
            if (!req_live && cmd_queue.size() != 0 &&
                !(cmd_queue[0].drain_first && fb_writes_due.size() != 0) &&
                $urandom_range(0, 99) >= snd_idle_pct) begin
                cur_req <= cmd_queue.pop_front();
                req_live = 1'b1;
            end
            i_valid <= req_live;
        end
    end

    always @(posedge i_clk) begin : write_checker
        t_fb_write got, want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                got = {o_status, o_write_address, o_write_data, o_byte_count, o_last};
                if (fb_writes_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: status %0d addr %h data %h count %0d last %0d",
                                 got.status, got.address, got.data, got.count, got.last);
                end else begin
                    want = fb_writes_due.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"mismatch (exp/got): status %0d/%0d addr %h/%h ",
                                      "data %h/%h count %0d/%0d last %0d/%0d"},
                                     want.status, got.status, want.address, got.address,
                                     want.data, got.data, want.count, got.count,
                                     want.last, got.last);
                    end
                end
            end
            if (holdoff_go) begin
                holdoff_go = 1'b0;
                hold_left = HOLDOFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** framebuffer_rect_blit_fill: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        t_cfg              cfg;
        int                ph;
        static int         snd_pct[4] = '{0, 53, 0, 15};
        static int         rcv_pct[4] = '{0, 0, 53, 15};
        static logic [2:0] ph_bpp[4] = '{3'd2, 3'd3, 3'd4, 3'd1};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset configuration: error cases, flip, fill, replace, abort
        add_pixel(24'hFFFFFF);
        queue_req(rand_req(CMD_UNUSED));
        add_start(CMD_BLIT, 0, 0, 0, 1, 1'b0, 24'h000000, 1'b0);
        add_start(CMD_FILL, 0, 0, 1, 0, 1'b0, 24'hFFFFFF, 1'b0);
        add_start(CMD_BLIT, 1919, 0, 2, 1, 1'b0, 24'h000000, 1'b0);
        add_start(CMD_FILL, 0, 1079, 1, 2, 1'b0, 24'h000000, 1'b0);
        add_start(CMD_BLIT, 1918, 1078, 2, 2, 1'b1, 24'h000000, 1'b0);
        add_pixel(24'h000000);
        add_pixel(24'hFFFFFF);
        add_pixel(24'hFF0055);
        add_pixel(24'h00FFAA);
        add_start(CMD_FILL, 0, 0, 3, 1, 1'b1, 24'hFF8001, 1'b0);
        repeat (3) add_pixel($urandom_range(0, 24'hFFFFFF));
        add_start(CMD_BLIT, 5, 5, 2, 2, 1'b0, 24'h000000, 1'b0);
        add_pixel(24'h123456);
        add_start(CMD_FILL, 7, 7, 1, 1, 1'b0, 24'h123456, 1'b0);
        add_pixel(24'hABCDEF);
        add_start(CMD_BLIT, 0, 0, 4, 4, 1'b0, 24'h000000, 1'b0);
        add_pixel(24'h5A5A5A);
        add_start(CMD_BLIT, 0, 0, 0, 0, 1'b0, 24'h000000, 1'b0);
        add_pixel(24'hA5A5A5);
        wait_drained();

        // register maxima: size limit, largest rectangle, address wrap
        program_cfg('{screen_width: 13'd8191, screen_height: 13'd8191,
                      pan_x: 12'd4095, pan_y: 13'd8191, line_stride: 16'd65535,
                      bytes_per_pixel: 3'd7, channel_layout: 27'h7FF_FFFF,
                      frame_base: 32'hFFFF_FFFF});
        add_start(CMD_BLIT, 0, 0, 4097, 1, 1'b0, 24'h000000, 1'b0);
        add_start(CMD_FILL, 0, 0, 1, 4097, 1'b0, 24'h000000, 1'b0);
        add_start(CMD_BLIT, 4095, 4095, 4096, 4096, 1'b1, 24'h000000, 1'b0);
        add_pixel(24'hFFFFFF);
        add_pixel(24'h000000);
        add_pixel(24'h80FF01);
        add_start(CMD_FILL, 4095, 4095, 1, 2, 1'b0, 24'hFFFFFF, 1'b0);
        repeat (2) add_pixel($urandom_range(0, 24'hFFFFFF));
        add_start(CMD_BLIT, 0, 0, 2, 2, 1'b0, 24'h000000, 1'b1);
        repeat (4) add_pixel($urandom_range(0, 24'hFFFFFF));
        add_start(CMD_BLIT, 1, 1, 3, 3, 1'b1, 24'h000000, 1'b0);
        repeat (2) add_pixel($urandom_range(0, 24'hFFFFFF));
        wait_drained();

        // register minima with the last rectangle still open
        program_cfg('{screen_width: 13'd0, screen_height: 13'd0, pan_x: 12'd0,
                      pan_y: 13'd0, line_stride: 16'd1, bytes_per_pixel: 3'd0,
                      channel_layout: 27'd0, frame_base: 32'd0});
        snd_idle_pct = 53;
        repeat (7) add_pixel($urandom_range(0, 24'hFFFFFF));
        add_start(CMD_BLIT, 0, 0, 1, 1, 1'b0, 24'h000000, 1'b0);
        add_start(CMD_FILL, 0, 0, 1, 1, 1'b0, 24'hFFFFFF, 1'b0);
        add_pixel(24'h000000);
        queue_req(rand_req(CMD_UNUSED));

        for (ph = 0; ph < 4; ph++) begin
            wait_drained();
            cfg = rand_cfg(ph_bpp[ph]);
            if (ph == 3) begin
                cfg.screen_width = 13'd4096;
                cfg.screen_height = 13'd4096;
            end
            program_cfg(cfg);
            snd_idle_pct = snd_pct[ph];
            rcv_stall_pct = rcv_pct[ph];
            gen_traffic(130);
            if (ph == 0) holdoff_go = 1'b1;
        end
        wait_drained();
        repeat (8) @(posedge i_clk);

        if (fail_count == 0 && fb_writes_due.size() == 0) begin
            $display("** framebuffer_rect_blit_fill: PASSED **");
        end else begin
            $display("** framebuffer_rect_blit_fill: FAILED **");
        end
        $finish;
    end

endmodule
